// ===== rtl/core/ptsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ptsc_pkg;

	localparam int PATH_DEPTH = 1024;
	localparam int ADDR_W     = $clog2(PATH_DEPTH);
	localparam int LEN_W      = $clog2(PATH_DEPTH + 1);

	localparam logic [1:0] CMD_CLEAR   = 2'd0;
	localparam logic [1:0] CMD_APPEND  = 2'd1;
	localparam logic [1:0] CMD_RESTART = 2'd2;
	localparam logic [1:0] CMD_POSE    = 2'd3;

	localparam logic [2:0] REG_LOOK_AHEAD = 3'd0;
	localparam logic [2:0] REG_MAX_SPEED  = 3'd1;
	localparam logic [2:0] REG_SPEED_GAIN = 3'd2;
	localparam logic [2:0] REG_HEAD_GAIN  = 3'd3;
	localparam logic [2:0] REG_PREV_GAIN  = 3'd4;
	localparam logic [2:0] REG_WINDOW     = 3'd5;

	localparam logic [23:0] RST_LOOK_AHEAD = 24'd65536;
	localparam logic [14:0] RST_MAX_SPEED  = 15'd256;
	localparam logic [15:0] RST_SPEED_GAIN = 16'd2458;
	localparam logic [15:0] RST_HEAD_GAIN  = 16'd1638;
	localparam logic [15:0] RST_PREV_GAIN  = 16'd41;
	localparam logic [7:0]  RST_WINDOW     = 8'd30;

	localparam int CORDIC_STEPS = 16;
	localparam logic signed [19:0] PI_Q13      = 20'sd25736;
	localparam logic signed [19:0] TWO_PI_Q13  = 20'sd51472;
	localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;

	// arctangent of 2^-i in units of 2^-16 rad
	function automatic logic signed [19:0] atan_entry(input logic [3:0] i);
		logic signed [19:0] r;
		case (i)
			4'd0: r = 20'sd51472;
			4'd1: r = 20'sd30386;
			4'd2: r = 20'sd16055;
			4'd3: r = 20'sd8150;
			4'd4: r = 20'sd4091;
			4'd5: r = 20'sd2047;
			4'd6: r = 20'sd1024;
			4'd7: r = 20'sd512;
			4'd8: r = 20'sd256;
			4'd9: r = 20'sd128;
			4'd10: r = 20'sd64;
			4'd11: r = 20'sd32;
			4'd12: r = 20'sd16;
			4'd13: r = 20'sd8;
			4'd14: r = 20'sd4;
			default: r = 20'sd2;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/path_tracking_steering_controller_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Pure pursuit steering: clear, append and restart are handled without leaving idle; an append gives its
// result (path_overflow) on the done strobe in the next cycle. A pose step walks the path
// store, one point issued per memory read cycle: the nearest-point scan over the search
// range (points 1 to length-1 on a full search, else up to 2*search_window points) and its
// pipeline drain, then the forward walk to the look-ahead point, which stops issuing once
// that point is found, and its drain, then the normalize shifts, the CORDIC iterations and the
// error, multiply and output states; busy stays high meanwhile. done is a single-cycle strobe
// and the receiver cannot stall it.
module path_tracking_steering_controller_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  command,
	input  wire logic [31:0] coord_x,
	input  wire logic [31:0] coord_y,
	input  wire logic [15:0] heading,
	output logic             done,
	output logic [15:0]      linear_speed,
	output logic [15:0]      angular_speed,
	output logic [9:0]       target_index,
	output logic             goal_reached,
	output logic             path_overflow,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import ptsc_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_NSCAN = 4'd1;
	localparam logic [3:0] ST_WSCAN = 4'd2;
	localparam logic [3:0] ST_NORM  = 4'd3;
	localparam logic [3:0] ST_ROT   = 4'd4;
	localparam logic [3:0] ST_CORD  = 4'd5;
	localparam logic [3:0] ST_ERR   = 4'd6;
	localparam logic [3:0] ST_MUL   = 4'd7;
	localparam logic [3:0] ST_OUT   = 4'd8;

	function automatic logic [15:0] sat16(input logic signed [35:0] v);
		logic [15:0] r;
		if (v > 36'sd32767) r = 16'h7fff;
		else if (v < -36'sd32768) r = 16'h8000;
		else r = v[15:0];
		return r;
	endfunction

	// configuration
	logic [23:0] la_q;
	logic [14:0] ms_q;
	logic [15:0] srg_q, hg_q, peg_q;
	logic [7:0]  win_q;

	// control state
	logic [3:0]       state_q;
	logic [LEN_W-1:0] len_q;
	logic [ADDR_W-1:0] lni_q;
	logic             nv_q;
	logic signed [15:0] pe_q;
	logic             goal_q;

	// pose work registers
	logic signed [31:0] x_q, y_q;
	logic signed [15:0] yaw_q;
	logic [47:0]        la2_q;
	logic [LEN_W-1:0]   cnt_q, end_q;
	logic               first_q, found_q;
	logic [63:0]        best_q;
	logic [ADDR_W-1:0]  near_q, tgt_q;
	logic signed [33:0] nx_q, ny_q;
	logic signed [35:0] cx_q, cy_q;
	logic signed [19:0] cz_q;
	logic [3:0]         it_q;
	logic signed [15:0] e_q;
	logic [31:0]        plin_q;
	logic signed [32:0] ph_q, pp_q;

	// scan pipeline
	logic               v_s1, v_s2, v_s3;
	logic [ADDR_W-1:0]  idx_s1, idx_s2, idx_s3;
	logic signed [31:0] px_s1, py_s1;
	logic signed [32:0] dx_s2, dy_s2, dx_s3, dy_s3;
	logic [31:0]        ax_s2, ay_s2;
	logic [63:0]        sqx_s3, sqy_s3;

	logic signed [31:0] mem_x [PATH_DEPTH];
	logic signed [31:0] mem_y [PATH_DEPTH];

	logic accept, we, issue, drained;
	logic [ADDR_W-1:0] rd_addr;
	logic [64:0] dsum;
	logic [63:0] dist_sq;
	logic [LEN_W-1:0] lo_idx, hi_sum, hi_idx;
	logic [33:0] mx, my;
	logic signed [19:0] ang_q13, e0, e1, e2;
	logic signed [35:0] sy_sh, sx_sh;
	logic [15:0] ae;
	logic [15:0] red;
	logic signed [35:0] lin_full, ang_full;
	logic cfg_wr;
	logic [2:0] cfg_idx;

	assign busy    = state_q != ST_IDLE;
	assign accept  = start && !busy;
	assign we      = accept && command == CMD_APPEND && len_q < LEN_W'(PATH_DEPTH);
	assign issue   = (state_q == ST_NSCAN || state_q == ST_WSCAN) && cnt_q < end_q && !found_q;
	assign rd_addr = cnt_q[ADDR_W-1:0];
	assign drained = !issue && !v_s1 && !v_s2 && !v_s3;

	assign dsum    = {1'b0, sqx_s3} + {1'b0, sqy_s3};
	assign dist_sq = dsum[64] ? '1 : dsum[63:0];

	// windowed search range, lower end clamped to one
	assign lo_idx = ({1'b0, lni_q} > (LEN_W'(win_q) + LEN_W'(1))) ?
		({1'b0, lni_q} - LEN_W'(win_q)) : LEN_W'(1);
	assign hi_sum = {1'b0, lni_q} + LEN_W'(win_q);
	assign hi_idx = (hi_sum > len_q) ? len_q : hi_sum;

	assign mx = nx_q[33] ? 34'(-nx_q) : 34'(nx_q);
	assign my = ny_q[33] ? 34'(-ny_q) : 34'(ny_q);

	assign sy_sh = cy_q >>> it_q;
	assign sx_sh = cx_q >>> it_q;

	always_comb begin
		ang_q13 = (cz_q + 20'sd4) >>> 3;
		e0 = ang_q13 - 20'(yaw_q);
		e1 = (e0 < -PI_Q13) ? e0 + TWO_PI_Q13 : e0;
		e2 = (e1 > PI_Q13) ? e1 - TWO_PI_Q13 : e1;
	end

	assign ae       = e_q[15] ? 16'(-e_q) : 16'(e_q);
	assign red      = 16'(({1'b0, plin_q} + 33'd65536) >> 17);
	assign lin_full = 36'(signed'({21'd0, ms_q})) - 36'(signed'({20'd0, red}));
	assign ang_full = (36'(ph_q) + 36'(pp_q) + 36'sd2048) >>> 12;

	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[4:2];
	assign pready  = 1'b1;

	always_comb begin
		case (cfg_idx)
			REG_LOOK_AHEAD: prdata = {8'd0, la_q};
			REG_MAX_SPEED:  prdata = {17'd0, ms_q};
			REG_SPEED_GAIN: prdata = {16'd0, srg_q};
			REG_HEAD_GAIN:  prdata = {16'd0, hg_q};
			REG_PREV_GAIN:  prdata = {16'd0, peg_q};
			REG_WINDOW:     prdata = {24'd0, win_q};
			default:        prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			la_q  <= RST_LOOK_AHEAD;
			ms_q  <= RST_MAX_SPEED;
			srg_q <= RST_SPEED_GAIN;
			hg_q  <= RST_HEAD_GAIN;
			peg_q <= RST_PREV_GAIN;
			win_q <= RST_WINDOW;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_LOOK_AHEAD: la_q  <= pwdata[23:0];
				REG_MAX_SPEED:  ms_q  <= pwdata[14:0];
				REG_SPEED_GAIN: srg_q <= pwdata[15:0];
				REG_HEAD_GAIN:  hg_q  <= pwdata[15:0];
				REG_PREV_GAIN:  peg_q <= pwdata[15:0];
				REG_WINDOW:     win_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// path store: writes happen only while idle, read data is used only while
	// scanning, so the two never meet on one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem_x[len_q[ADDR_W-1:0]] <= coord_x;
			mem_y[len_q[ADDR_W-1:0]] <= coord_y;
		end
		px_s1 <= mem_x[rd_addr];
		py_s1 <= mem_y[rd_addr];
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_addr;
		idx_s2 <= idx_s1;
		dx_s2  <= 33'(px_s1) - 33'(x_q);
		dy_s2  <= 33'(py_s1) - 33'(y_q);
		idx_s3 <= idx_s2;
		dx_s3  <= dx_s2;
		dy_s3  <= dy_s2;
		sqx_s3 <= ax_s2 * ax_s2;
		sqy_s3 <= ay_s2 * ay_s2;
	end

	assign ax_s2 = dx_s2[32] ? 32'(-dx_s2) : dx_s2[31:0];
	assign ay_s2 = dy_s2[32] ? 32'(-dy_s2) : dy_s2[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q   <= '0;
			lni_q   <= '0;
			nv_q    <= 1'b0;
			pe_q    <= '0;
			goal_q  <= 1'b0;
			cnt_q   <= '0;
			end_q   <= '0;
			first_q <= 1'b0;
			found_q <= 1'b0;
			done          <= 1'b0;
			linear_speed  <= '0;
			angular_speed <= '0;
			target_index  <= '0;
			goal_reached  <= 1'b0;
			path_overflow <= 1'b0;
		end else begin
			done <= 1'b0;
			if (issue) cnt_q <= cnt_q + LEN_W'(1);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (command)
							CMD_CLEAR: begin
								len_q <= '0;
								lni_q <= '0;
								nv_q  <= 1'b0;
							end
							CMD_APPEND: begin
								if (we) len_q <= len_q + LEN_W'(1);
								done          <= 1'b1;
								linear_speed  <= '0;
								angular_speed <= '0;
								target_index  <= '0;
								goal_reached  <= 1'b0;
								path_overflow <= !we;
							end
							CMD_RESTART: begin
								nv_q   <= 1'b0;
								goal_q <= 1'b0;
							end
							default: begin
								x_q   <= coord_x;
								y_q   <= coord_y;
								yaw_q <= heading;
								la2_q <= la_q * la_q;
								if (goal_q) begin
									done          <= 1'b1;
									linear_speed  <= '0;
									angular_speed <= '0;
									target_index  <= '0;
									goal_reached  <= 1'b1;
									path_overflow <= 1'b0;
								end else begin
									near_q  <= lni_q;
									first_q <= 1'b1;
									found_q <= 1'b0;
									cnt_q   <= nv_q ? lo_idx : LEN_W'(1);
									end_q   <= nv_q ? hi_idx : len_q;
									state_q <= ST_NSCAN;
								end
							end
						endcase
					end
				end
				ST_NSCAN: begin
					// strict less-than keeps the lowest index on ties
					if (v_s3 && (first_q || dist_sq < best_q)) begin
						best_q  <= dist_sq;
						near_q  <= idx_s3;
						first_q <= 1'b0;
					end
					if (drained) begin
						lni_q   <= near_q;
						nv_q    <= 1'b1;
						cnt_q   <= {1'b0, near_q};
						end_q   <= len_q;
						state_q <= ST_WSCAN;
					end
				end
				ST_WSCAN: begin
					if (v_s3 && !found_q && dist_sq >= {16'd0, la2_q}) begin
						found_q <= 1'b1;
						tgt_q   <= idx_s3;
						nx_q    <= 34'(dx_s3);
						ny_q    <= 34'(dy_s3);
					end
					if (drained) begin
						if (found_q) begin
							state_q <= ST_NORM;
						end else begin
							goal_q        <= 1'b1;
							done          <= 1'b1;
							linear_speed  <= '0;
							angular_speed <= '0;
							target_index  <= '0;
							goal_reached  <= 1'b1;
							path_overflow <= 1'b0;
							state_q       <= ST_IDLE;
						end
					end
				end
				ST_NORM: begin
					if (mx == '0 && my == '0) begin
						cz_q    <= '0;
						state_q <= ST_ERR;
					end else if (mx[33:31] == 3'd0 && my[33:31] == 3'd0) begin
						nx_q <= nx_q <<< 1;
						ny_q <= ny_q <<< 1;
					end else begin
						state_q <= ST_ROT;
					end
				end
				ST_ROT: begin
					it_q <= '0;
					// left half plane: quarter turn first
					if (nx_q < 0) begin
						if (ny_q >= 0) begin
							cx_q <= 36'(ny_q);
							cy_q <= -36'(nx_q);
							cz_q <= HALF_PI_Q16;
						end else begin
							cx_q <= -36'(ny_q);
							cy_q <= 36'(nx_q);
							cz_q <= -HALF_PI_Q16;
						end
					end else begin
						cx_q <= 36'(nx_q);
						cy_q <= 36'(ny_q);
						cz_q <= '0;
					end
					state_q <= ST_CORD;
				end
				ST_CORD: begin
					if (cy_q >= 0) begin
						cx_q <= cx_q + sy_sh;
						cy_q <= cy_q - sx_sh;
						cz_q <= cz_q + atan_entry(it_q);
					end else begin
						cx_q <= cx_q - sy_sh;
						cy_q <= cy_q + sx_sh;
						cz_q <= cz_q - atan_entry(it_q);
					end
					it_q <= it_q + 4'd1;
					if (it_q == 4'(CORDIC_STEPS - 1)) state_q <= ST_ERR;
				end
				ST_ERR: begin
					e_q     <= e2[15:0];
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					plin_q  <= srg_q * ae;
					ph_q    <= signed'({1'b0, hg_q}) * e_q;
					pp_q    <= signed'({1'b0, peg_q}) * pe_q;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					pe_q          <= e_q;
					done          <= 1'b1;
					linear_speed  <= sat16(lin_full);
					angular_speed <= sat16(ang_full);
					target_index  <= 10'(tgt_q);
					goal_reached  <= 1'b0;
					path_overflow <= 1'b0;
					state_q       <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(PATH_DEPTH))
		else $error("path length beyond store depth");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> state_q == ST_IDLE)
		else $error("result strobe while a pose is still at work");

	a_scan_only: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (state_q == ST_NSCAN || state_q == ST_WSCAN))
		else $error("path read outside a scan");

	a_goal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && goal_reached) |-> (linear_speed == 16'd0 && angular_speed == 16'd0))
		else $error("goal result with nonzero speed");

endmodule
`default_nettype wire

// ===== test/path_tracking_steering_controller_top_tb.sv =====
`timescale 1ns / 1ps
module path_tracking_steering_controller_top_tb;
	import ptsc_pkg::*;

	typedef struct packed {
		logic [15:0] lin;
		logic [15:0] ang;
		logic [9:0]  tidx;
		logic        goal;
		logic        ovf;
	} steer_t;

	typedef struct {
		logic [1:0]  cmd;
		logic [31:0] x;
		logic [31:0] y;
		logic [15:0] hd;
		bit          known;
		steer_t      res;
	} row_t;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 80;
	localparam int RANDOM_ITEMS   = 120;

	localparam longint ARCTAN_Q16 [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2};

	logic clk, arst_n, start, busy, done;
	logic [1:0] command;
	logic [31:0] coord_x, coord_y;
	logic [15:0] heading;
	logic [15:0] linear_speed, angular_speed;
	logic [9:0] target_index;
	logic goal_reached, path_overflow;
	logic psel, penable, pwrite, pready;
	logic [4:0] paddr;
	logic [31:0] pwdata, prdata;

	path_tracking_steering_controller_top uut (.*);

	// predictor state
	logic signed [31:0] path_x [PATH_DEPTH];
	logic signed [31:0] path_y [PATH_DEPTH];
	int unsigned path_len, last_near;
	bit near_ok, goal_hold;
	int signed prev_err;
	logic [23:0] la_dist;
	logic [14:0] max_spd;
	logic [15:0] spd_gain, head_gain, prev_gain;
	logic [7:0] window;

	steer_t expected_steer [$];
	int errors, n_items, n_results, n_goal, n_ovf, n_steer, next_gap;
	int quiet;

	initial begin
		clk = 0;
		forever begin
			#5 clk = 1;
			#5 clk = 0;
		end
	end

	function automatic logic [63:0] range2(int unsigned i, longint x, longint y);
		longint dx, dy;
		logic [63:0] ux, uy;
		logic [64:0] s;
		dx = longint'(path_x[i]) - x;
		dy = longint'(path_y[i]) - y;
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		ux = dx;
		uy = dy;
		s = {1'b0, ux * ux} + {1'b0, uy * uy};
		return s[64] ? '1 : s[63:0];
	endfunction

	function automatic int signed bearing_q13(longint dx, longint dy);
		longint x, y, z, nx, ax, ay, m;
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		m = ax > ay ? ax : ay;
		z = 0;
		if (m == 0) return 0;
		while (m < 64'sd2147483648) begin
			dx = dx * 2;
			dy = dy * 2;
			m = m * 2;
		end
		x = dx;
		y = dy;
		// quarter turn into the right half plane
		if (x < 0) begin
			if (y >= 0) begin
				x = dy; y = -dx; z = 102944;
			end else begin
				x = -dy; y = dx; z = -102944;
			end
		end
		for (int i = 0; i < 16; i++) begin
			if (y >= 0) begin
				nx = x + (y >>> i); y = y - (x >>> i); z += ARCTAN_Q16[i];
			end else begin
				nx = x - (y >>> i); y = y + (x >>> i); z -= ARCTAN_Q16[i];
			end
			x = nx;
		end
		return int'((z + 4) >>> 3);
	endfunction

	function automatic logic [15:0] clip16(longint v);
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[15:0];
	endfunction

	// returns 1 when the command produces a result
	function automatic bit predict_steer(logic [1:0] cmd, logic [31:0] px, logic [31:0] py,
			logic [15:0] hd, output steer_t r);
		longint x, y, yaw, ae, lin, ang;
		int unsigned i0, i1, nearest, tgt;
		logic [63:0] best, d, la2;
		bit found;
		int signed e;
		x = longint'($signed(px));
		y = longint'($signed(py));
		yaw = longint'($signed(hd));
		r = '0;
		found = 0;
		tgt = 0;
		best = 0;
		case (cmd)
			CMD_CLEAR: begin
				path_len = 0; last_near = 0; near_ok = 0;
				return 0;
			end
			CMD_APPEND: begin
				if (path_len < PATH_DEPTH) begin
					path_x[path_len] = px; path_y[path_len] = py; path_len++;
				end else r.ovf = 1;
				return 1;
			end
			CMD_RESTART: begin
				near_ok = 0; goal_hold = 0;
				return 0;
			end
			default: ;
		endcase
		r.goal = 1;
		if (goal_hold) return 1;
		if (!near_ok) begin
			i0 = 1; i1 = path_len;
		end else begin
			i0 = (last_near > window + 1) ? last_near - window : 1;
			i1 = last_near + window;
			if (i1 > path_len) i1 = path_len;
		end
		nearest = last_near;
		for (int unsigned i = i0; i < i1; i++) begin
			d = range2(i, x, y);
			if (i == i0 || d < best) begin
				best = d; nearest = i;
			end
		end
		last_near = nearest;
		near_ok = 1;
		la2 = 64'(la_dist) * 64'(la_dist);
		for (int unsigned i = nearest; i < path_len; i++)
			if (range2(i, x, y) >= la2) begin
				tgt = i; found = 1; break;
			end
		if (!found) begin
			goal_hold = 1;
			return 1;
		end
		e = bearing_q13(longint'(path_x[tgt]) - x, longint'(path_y[tgt]) - y) - int'(yaw);
		if (e < -25736) e += 51472;
		if (e > 25736) e -= 51472;
		ae = e < 0 ? -longint'(e) : longint'(e);
		lin = longint'(max_spd) - ((longint'(spd_gain) * ae + 65536) >>> 17);
		ang = (longint'(head_gain) * e + longint'(prev_gain) * prev_err + 2048) >>> 12;
		prev_err = e;
		r.lin = clip16(lin);
		r.ang = clip16(ang);
		r.tidx = tgt[9:0];
		r.goal = 0;
		return 1;
	endfunction

	task automatic send(logic [1:0] cmd, logic [31:0] x, logic [31:0] y, logic [15:0] hd,
			bit known = 0, steer_t typed = '0);
		steer_t r;
		if (next_gap > 0) begin
			start <= 0;
			repeat (next_gap) @(posedge clk);
		end
		start <= 1;
		command <= cmd;
		coord_x <= x;
		coord_y <= y;
		heading <= hd;
		do @(posedge clk); while (busy);
		if (predict_steer(cmd, x, y, hd, r)) expected_steer = {expected_steer, known ? typed : r};
		n_items++;
		next_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
	endtask

	task automatic settle();
		start <= 0;
		next_gap = 1;
		@(posedge clk);
		while (expected_steer.size() != 0 || busy) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] v);
		psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (idx)
			REG_LOOK_AHEAD: la_dist = v[23:0];
			REG_MAX_SPEED:  max_spd = v[14:0];
			REG_SPEED_GAIN: spd_gain = v[15:0];
			REG_HEAD_GAIN:  head_gain = v[15:0];
			REG_PREV_GAIN:  prev_gain = v[15:0];
			REG_WINDOW:     window = v[7:0];
			default: ;
		endcase
	endtask

	function automatic logic [15:0] pick_heading();
		if ($urandom_range(0, 9) == 0) return 16'($urandom);
		return 16'($signed($urandom_range(0, 51472)) - 25736);
	endfunction

	task automatic load_settings(int k);
		logic [31:0] la;
		case (k % 5)
			0: la = 0;
			1: la = 24'hFFFFFF;
			default: la = $urandom_range(1 << 14, 3 << 16);
		endcase
		write_reg(REG_LOOK_AHEAD, la | ($urandom & 32'hFF000000));
		write_reg(REG_MAX_SPEED, (k % 4 == 1) ? 32'h7FFF : (k % 4 == 2) ? 0 : $urandom);
		write_reg(REG_SPEED_GAIN, (k % 3 == 1) ? 32'hFFFF : (k % 3 == 2) ? 0 : $urandom);
		write_reg(REG_HEAD_GAIN, (k % 3 == 2) ? 32'hFFFF : (k % 3 == 0) ? 0 : $urandom);
		write_reg(REG_PREV_GAIN, (k % 4 == 3) ? 32'hFFFF : (k % 4 == 0) ? 0 : $urandom);
		write_reg(REG_WINDOW, (k % 3 == 0) ? 1 : (k % 3 == 1) ? 255 : $urandom_range(1, 20));
	endtask

	// result checker
	always @(posedge clk) begin
		if (done) begin
			if (expected_steer.size() == 0) begin
				$display("%t unexpected result lin=%h ang=%h tidx=%0d goal=%b ovf=%b", $realtime,
					linear_speed, angular_speed, target_index, goal_reached, path_overflow);
				errors++;
			end else begin
				steer_t w;
				w = expected_steer.pop_front();
				if (w.lin !== linear_speed) begin
					$display("%t linear_speed expected %h actual %h", $realtime, w.lin,
						linear_speed);
					errors++;
				end
				if (w.ang !== angular_speed) begin
					$display("%t angular_speed expected %h actual %h", $realtime, w.ang,
						angular_speed);
					errors++;
				end
				if (w.tidx !== target_index) begin
					$display("%t target_index expected %0d actual %0d", $realtime, w.tidx,
						target_index);
					errors++;
				end
				if (w.goal !== goal_reached) begin
					$display("%t goal_reached expected %b actual %b", $realtime, w.goal,
						goal_reached);
					errors++;
				end
				if (w.ovf !== path_overflow) begin
					$display("%t path_overflow expected %b actual %b", $realtime, w.ovf,
						path_overflow);
					errors++;
				end
			end
			n_results++;
			if (goal_reached === 1'b1) n_goal++;
			if (path_overflow === 1'b1) n_ovf++;
			if (goal_reached === 1'b0 && path_overflow === 1'b0 && target_index != 0) n_steer++;
		end
	end

	// watchdog on transfers
	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("%t watchdog: no transfer for %0d cycles", $realtime, quiet);
			$display("path_tracking_steering_controller_top: mismatch");
			$finish;
		end
	end

	initial begin
		row_t dir [$];
		row_t rw;
		steer_t zero_res, goal_res;
		logic signed [31:0] bx, by, sx, sy;
		int n, k, phase;

		arst_n = 0; start = 0; command = CMD_CLEAR; coord_x = 0; coord_y = 0; heading = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		errors = 0; n_items = 0; n_results = 0; n_goal = 0; n_ovf = 0; n_steer = 0;
		next_gap = 0;
		path_len = 0; last_near = 0; near_ok = 0; prev_err = 0; goal_hold = 0;
		la_dist = RST_LOOK_AHEAD; max_spd = RST_MAX_SPEED; spd_gain = RST_SPEED_GAIN;
		head_gain = RST_HEAD_GAIN; prev_gain = RST_PREV_GAIN; window = RST_WINDOW;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		zero_res = '0;
		goal_res = '0;
		goal_res.goal = 1;
		// directed: reset defaults, empty path, latched goal, coordinate and yaw extremes
		dir = '{
			'{CMD_POSE, 0, 0, 0, 1, goal_res},
			'{CMD_POSE, 32'h7FFFFFFF, 32'h80000000, 16'h8000, 1, goal_res},
			'{CMD_CLEAR, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 0, zero_res},
			'{CMD_POSE, 0, 0, 0, 1, goal_res},
			'{CMD_RESTART, 0, 0, 0, 0, zero_res},
			'{CMD_APPEND, 0, 0, 0, 1, zero_res},
			'{CMD_APPEND, 32'h00010000, 0, 0, 1, zero_res},
			'{CMD_APPEND, 32'h00030000, 32'h00010000, 0, 1, zero_res},
			'{CMD_APPEND, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF, 1, zero_res},
			'{CMD_APPEND, 32'h80000000, 32'h80000000, 0, 1, zero_res},
			'{CMD_POSE, 0, 0, 0, 0, zero_res},
			'{CMD_POSE, 32'h00008000, 0, 16'd25736, 0, zero_res},
			'{CMD_POSE, 32'h00008000, 32'hFFFF0000, 16'hDB78, 0, zero_res},
			'{CMD_POSE, 32'h00020000, 32'h00010000, 16'h7FFF, 0, zero_res},
			'{CMD_POSE, 32'h80000000, 32'h7FFFFFFF, 16'h8000, 0, zero_res},
			'{CMD_RESTART, 0, 0, 0, 0, zero_res},
			'{CMD_POSE, 32'hFFFF0000, 32'h00010000, 16'h6488, 0, zero_res},
			'{CMD_POSE, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, zero_res},
			'{CMD_CLEAR, 0, 0, 0, 0, zero_res},
			'{CMD_POSE, 0, 0, 0, 1, goal_res},
			'{CMD_RESTART, 0, 0, 0, 0, zero_res},
			'{CMD_POSE, 0, 0, 0, 1, goal_res}
		};
		foreach (dir[i]) begin
			rw = dir[i];
			send(rw.cmd, rw.x, rw.y, rw.hd, rw.known, rw.res);
		end
		settle();

		// random phases: well-formed paths with poses along them, some noise
		phase = 0;
		while (n_items < RANDOM_ITEMS) begin
			load_settings(phase);
			phase++;
			send(CMD_CLEAR, $urandom, $urandom, 16'($urandom));
			send(CMD_RESTART, $urandom, $urandom, 16'($urandom));
			bx = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
			by = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
			sx = $signed($urandom_range(0, 1 << 17)) - (1 << 16);
			sy = $signed($urandom_range(0, 1 << 17)) - (1 << 16);
			n = $urandom_range(2, 40);
			for (int i = 0; i < n; i++) begin
				send(CMD_APPEND, bx + i * sx, by + i * sy, 16'($urandom));
				sx += $signed($urandom_range(0, 8192)) - 4096;
				sy += $signed($urandom_range(0, 8192)) - 4096;
			end
			repeat ($urandom_range(10, 30)) begin
				k = $urandom_range(0, 19);
				if (k == 0) send(CMD_RESTART, $urandom, $urandom, 16'($urandom));
				else if (k == 1)
					send(2'($urandom_range(0, 3)), $urandom, $urandom, 16'($urandom));
				else if (k == 2) send(CMD_APPEND, bx + $urandom_range(0, 1 << 20), by, 0);
				else begin
					k = $urandom_range(0, path_len > 0 ? path_len - 1 : 0);
					send(CMD_POSE, path_x[k] + $signed($urandom_range(0, 1 << 17)) - (1 << 16),
						path_y[k] + $signed($urandom_range(0, 1 << 17)) - (1 << 16),
						pick_heading());
				end
			end
			settle();
		end

		// fill the whole store, then one append too many
		load_settings(2);
		send(CMD_CLEAR, 0, 0, 0);
		send(CMD_RESTART, 0, 0, 0);
		for (int i = 0; i < PATH_DEPTH; i++)
			send(CMD_APPEND, i * 32'h4000, (i % 7) * 32'h2000, 0);
		send(CMD_APPEND, 32'h12345678, 32'h9ABCDEF0, 0, 1, '{0, 0, 0, 0, 1});
		send(CMD_POSE, 32'h00100000, 0, 0);
		send(CMD_POSE, 32'h00FF0000, 32'h00010000, pick_heading());
		send(CMD_RESTART, 0, 0, 0);
		send(CMD_POSE, 32'h00C00000, 0, pick_heading());
		settle();

		$display("items %0d, results %0d: %0d steering, %0d goal reached, %0d overflow",
			n_items, n_results, n_steer, n_goal, n_ovf);
		$display("%0d register settings, path lengths up to the full store", phase + 2);
		if (errors == 0) $display("path_tracking_steering_controller_top: match");
		else $display("path_tracking_steering_controller_top: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/ptsc_pkg.sv
rtl/core/path_tracking_steering_controller_top.sv
test/path_tracking_steering_controller_top_tb.sv
